[rtl/lrs_pkg.sv]
// shared types, codes and constants of the link role switch sequencer
// no dependencies; compile first
package lrs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_LEAVE_LP  = 3'd1,
        ST_PAUSE_ENC = 3'd2,
        ST_ROLE      = 3'd3,
        ST_ROLE_FAST = 3'd4,
        ST_RESTORE   = 3'd5
    } lrs_state_t;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_EVENT   = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_ERROR   = 2'd3
    } lrs_kind_t;

    typedef enum logic [1:0] {
        EVT_ACTIVE  = 2'd0,
        EVT_ENC_OFF = 2'd1,
        EVT_ENC_ON  = 2'd2,
        EVT_OTHER   = 2'd3
    } lrs_evt_t;

    // encryption command codes
    localparam logic [1:0] ENC_NONE = 2'd0;
    localparam logic [1:0] ENC_OFF  = 2'd1;
    localparam logic [1:0] ENC_ON   = 2'd2;

    // notification request codes
    localparam logic [2:0] NTF_NONE    = 3'd0;
    localparam logic [2:0] NTF_ACTIVE  = 3'd1;
    localparam logic [2:0] NTF_ENC_OFF = 3'd2;
    localparam logic [2:0] NTF_ROLE    = 3'd3;
    localparam logic [2:0] NTF_ENC_ON  = 3'd4;

    // timer start codes
    localparam logic [1:0] TMR_NONE     = 2'd0;
    localparam logic [1:0] TMR_WATCHDOG = 2'd1;
    localparam logic [1:0] TMR_ONE_CMD  = 2'd2;

    // traffic park codes
    localparam logic [1:0] PARK_NONE    = 2'd0;
    localparam logic [1:0] PARK_SUSPEND = 2'd1;
    localparam logic [1:0] PARK_RESUME  = 2'd2;

    // configuration register indexes and port widths
    localparam logic REG_WANTED_ROLE = 1'b0;
    localparam logic REG_PAUSE_FREE  = 1'b1;
    localparam int   APB_AW = 3;
    localparam int   APB_DW = 32;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] event_type;
        logic       event_ok;
        logic       link_active;
        logic       link_encrypted;
    } lrs_item_t;

    typedef struct packed {
        logic [2:0] new_state;
        logic       cmd_leave_lowpower;
        logic       cmd_change_role;
        logic [1:0] cmd_encrypt;
        logic [2:0] notify_request;
        logic       notify_cancel;
        logic       timer_cancel;
        logic [1:0] timer_start;
        logic [1:0] traffic_park;
        logic       terminate_link;
        logic       release_helper;
        logic       fault;
    } lrs_result_t;

    typedef struct packed {
        logic wanted_role;
        logic pause_free_switch;
    } lrs_cfg_t;

endpackage

[rtl/lrs_if.sv]
// request and result channel interfaces of the role switch sequencer
// depends on lrs_pkg
interface lrs_item_if import lrs_pkg::*; ();
    logic      valid;
    logic      ready;
    lrs_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lrs_result_if import lrs_pkg::*; ();
    logic        valid;
    logic        ready;
    lrs_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/link_role_switch_sequencer.sv]
// top level of the link role switch sequencer: request and result registers,
// state registers; depends on lrs_pkg, lrs_if, lrs_cfg and lrs_step
//
//  channel  | direction | handshake      | carries
//  ---------+-----------+----------------+------------------------------------------
//  item     | in        | valid / ready  | kind, event_type, event_ok, link flags
//  result   | out       | valid / ready  | new state and merged actions of a request
//  apb      | in        | psel / penable | wanted_role (0x0), pause_free_switch (0x4)
//
// one request per cycle sustained while results are taken; an accepted request goes
// into the request register, then its decode into the result register, where it
// stays valid until taken
// the decode is one pass over the chained state entries, the position and saved
// encryption flag are updated when a request moves into the result register
// a stalled result holds; the request register takes a new request while it is
// empty or its request moves on into the result register
// rst_n clears the position to idle, the saved flag, the configuration and both
// valids; request and result data are not reset
module link_role_switch_sequencer import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lrs_item_if.sink          item,
    lrs_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    lrs_cfg_t    cfg;

    // request stage
    logic        req_vld_reg;
    logic        req_vld_next;
    lrs_item_t   req_reg;

    // result stage
    logic        res_vld_reg;
    logic        res_vld_next;
    lrs_result_t res_reg;

    // sequencer state
    lrs_state_t  pos_reg;
    lrs_state_t  pos_next;
    logic        sav_reg;
    logic        sav_next;

    lrs_result_t step_res;
    lrs_state_t  step_pos;
    logic        step_sav;
    logic        advance;

    lrs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrs_step u_step
    (
        .pos            (pos_reg),
        .saved_enc      (sav_reg),
        .pause_free     (cfg.pause_free_switch),
        .item           (req_reg),
        .pos_next       (step_pos),
        .saved_enc_next (step_sav),
        .res            (step_res)
    );

    // request moves on when the result register is empty or being drained
    assign advance     = req_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready  = !req_vld_reg || advance;

    always_comb
    begin
        req_vld_next = item.ready ? item.valid : req_vld_reg;
        res_vld_next = advance ? 1'b1 : (result.ready ? 1'b0 : res_vld_reg);
        pos_next     = advance ? step_pos : pos_reg;
        sav_next     = advance ? step_sav : sav_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
            pos_reg     <= ST_IDLE;
            sav_reg     <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            res_vld_reg <= res_vld_next;
            pos_reg     <= pos_next;
            sav_reg     <= sav_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            req_reg <= item.data;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid = res_vld_reg;
    assign result.data  = res_reg;

endmodule

[rtl/lrs_cfg.sv]
// apb configuration registers of the role switch sequencer
// depends on lrs_pkg
module lrs_cfg import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output lrs_cfg_t          cfg
);

    lrs_cfg_t cfg_reg;
    lrs_cfg_t cfg_next;
    logic     wr_en;
    logic     sel_idx;

    assign pready  = 1'b1;
    assign sel_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel_idx)
                REG_WANTED_ROLE: cfg_next.wanted_role       = pwdata[0];
                REG_PAUSE_FREE:  cfg_next.pause_free_switch = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (sel_idx)
            REG_WANTED_ROLE: prdata = {{(APB_DW-1){1'b0}}, cfg_reg.wanted_role};
            REG_PAUSE_FREE:  prdata = {{(APB_DW-1){1'b0}}, cfg_reg.pause_free_switch};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/lrs_step.sv]
// next-state and action decode for one request of the role switch sequencer
// depends on lrs_pkg
module lrs_step import lrs_pkg::*;
(
    input  lrs_state_t  pos,
    input  logic        saved_enc,
    input  logic        pause_free,
    input  lrs_item_t   item,
    output lrs_state_t  pos_next,
    output logic        saved_enc_next,
    output lrs_result_t res
);

    lrs_state_t pos0;
    lrs_state_t cur;
    lrs_state_t nxt;
    logic       go;
    logic       more;
    logic       sav;
    logic       ok;
    lrs_evt_t   etype;

    always_comb
    begin
        res   = '0;
        go    = 1'b0;
        more  = 1'b0;
        nxt   = ST_IDLE;
        ok    = item.event_ok;
        etype = lrs_evt_t'(item.event_type);
        sav   = saved_enc;
        // unused codes behave as idle
        pos0  = (pos > ST_RESTORE) ? ST_IDLE : pos;
        cur   = pos0;

        case (lrs_kind_t'(item.kind))
            KIND_START:
            begin
                if (pos0 == ST_IDLE)
                begin
                    res.timer_start = TMR_WATCHDOG;
                    go  = 1'b1;
                    nxt = ST_LEAVE_LP;
                end
                else
                begin
                    res.fault = 1'b1;
                end
            end
            KIND_ERROR:
            begin
                res.notify_cancel = 1'b1;
                res.timer_cancel  = 1'b1;
                go  = 1'b1;
                nxt = ST_IDLE;
            end
            KIND_TIMEOUT:
            begin
                go = 1'b1;
                case (pos0)
                    ST_PAUSE_ENC, ST_ROLE:
                    begin
                        res.notify_cancel = 1'b1;
                        nxt = ST_RESTORE;
                    end
                    ST_ROLE_FAST:
                    begin
                        res.notify_cancel = 1'b1;
                        nxt = ST_IDLE;
                    end
                    ST_RESTORE:
                    begin
                        res.notify_cancel  = 1'b1;
                        res.terminate_link = 1'b1;
                        nxt = ST_IDLE;
                    end
                    default: nxt = ST_IDLE;
                endcase
            end
            default:
            begin
                go = 1'b1;
                case (pos0)
                    ST_LEAVE_LP:
                    begin
                        if (etype == EVT_ACTIVE && ok)
                            nxt = pause_free ? ST_ROLE_FAST : ST_PAUSE_ENC;
                        else
                            nxt = ST_IDLE;
                    end
                    ST_PAUSE_ENC:
                    begin
                        nxt = (etype == EVT_ENC_OFF && ok) ? ST_ROLE : ST_IDLE;
                    end
                    ST_ROLE:
                    begin
                        res.timer_cancel = 1'b1;
                        nxt = ST_RESTORE;
                    end
                    ST_ROLE_FAST:
                    begin
                        res.timer_cancel = 1'b1;
                        nxt = ST_IDLE;
                    end
                    ST_RESTORE:
                    begin
                        res.timer_cancel = 1'b1;
                        if (!(etype == EVT_ENC_ON && ok))
                            res.terminate_link = 1'b1;
                        nxt = ST_IDLE;
                    end
                    default: go = 1'b0;
                endcase
            end
        endcase

        // leaving restore with encryption saved resumes traffic
        if (go && pos0 == ST_RESTORE && saved_enc)
            res.traffic_park = PARK_RESUME;
        more = go;

        // chained state entries, at most three per request
        for (int i = 0; i < 3; i++)
        begin
            if (more)
            begin
                cur  = nxt;
                more = 1'b0;
                case (cur)
                    ST_LEAVE_LP:
                    begin
                        res.cmd_leave_lowpower = 1'b1;
                        if (item.link_active)
                        begin
                            nxt  = pause_free ? ST_ROLE_FAST : ST_PAUSE_ENC;
                            more = 1'b1;
                        end
                        else
                        begin
                            res.notify_request = NTF_ACTIVE;
                        end
                    end
                    ST_PAUSE_ENC:
                    begin
                        sav = item.link_encrypted;
                        if (item.link_encrypted)
                        begin
                            res.traffic_park   = PARK_SUSPEND;
                            res.notify_request = NTF_ENC_OFF;
                            res.cmd_encrypt    = ENC_OFF;
                        end
                        else
                        begin
                            nxt  = ST_ROLE;
                            more = 1'b1;
                        end
                    end
                    ST_ROLE, ST_ROLE_FAST:
                    begin
                        res.notify_request  = NTF_ROLE;
                        res.cmd_change_role = 1'b1;
                    end
                    ST_RESTORE:
                    begin
                        if (sav)
                        begin
                            res.timer_start    = TMR_ONE_CMD;
                            res.notify_request = NTF_ENC_ON;
                            res.cmd_encrypt    = ENC_ON;
                        end
                        else
                        begin
                            nxt  = ST_IDLE;
                            more = 1'b1;
                        end
                    end
                    default:
                    begin
                        cur = ST_IDLE;
                        res.release_helper = 1'b1;
                    end
                endcase
            end
        end

        res.new_state  = cur;
        pos_next       = cur;
        saved_enc_next = sav;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for link_role_switch_sequencer: random and directed requests,
// a cycle-free predictor of the role switch steps and a field by field result check
// depends on lrs_pkg, lrs_if and the rtl of the sequencer
module tb;
    import lrs_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 4;    // two-stage pipe plus margin

    // position and saved encryption flag of the sequencer
    typedef struct packed {
        lrs_state_t pos;
        logic       saved_enc;
    } switch_state_t;

    logic clk = 1'b0;
    logic rst_n;

    // configuration port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lrs_item_if   item_ch();
    lrs_result_if result_ch();

    // requests waiting for the driver, and predicted actions waiting for results
    lrs_item_t     pending_requests[$];
    lrs_result_t   predicted_actions[$];

    // the generator walks its own copy of the state so that it can build
    // well-formed switch sequences ahead of the driver
    switch_state_t gen_state;
    switch_state_t chk_state;
    lrs_cfg_t      cur_cfg;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  requests_queued;
    int  requests_taken;
    int  mismatches;
    int  quiet_cycles;
    logic item_taken;

    link_role_switch_sequencer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch.sink),
        .result  (result_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // one role switch step: the transition picked by the request, then every
    // chained state entry, all actions merged into one result
    function automatic lrs_result_t role_switch_step(inout switch_state_t st,
                                                     input lrs_cfg_t cfg,
                                                     input lrs_item_t req);
        lrs_result_t r;
        lrs_state_t  target;
        logic        move;
        logic        chaining;
        r = '0;
        move = 1'b0;
        target = ST_IDLE;
        case (req.kind)
            KIND_START:
            begin
                // a start is only legal from idle, otherwise just flag it
                if (st.pos == ST_IDLE)
                begin
                    r.timer_start = TMR_WATCHDOG;
                    target = ST_LEAVE_LP;
                    move = 1'b1;
                end
                else
                    r.fault = 1'b1;
            end
            KIND_ERROR:
            begin
                r.notify_cancel = 1'b1;
                r.timer_cancel = 1'b1;
                move = 1'b1;
            end
            KIND_TIMEOUT:
            begin
                move = 1'b1;
                case (st.pos)
                    ST_PAUSE_ENC, ST_ROLE:
                    begin
                        r.notify_cancel = 1'b1;
                        target = ST_RESTORE;
                    end
                    ST_ROLE_FAST:
                        r.notify_cancel = 1'b1;
                    ST_RESTORE:
                    begin
                        r.notify_cancel = 1'b1;
                        r.terminate_link = 1'b1;
                    end
                    default:
                        target = ST_IDLE;
                endcase
            end
            default:
            begin
                // baseband event; ignored in idle
                case (st.pos)
                    ST_LEAVE_LP:
                    begin
                        move = 1'b1;
                        if (req.event_type == EVT_ACTIVE && req.event_ok)
                            target = cfg.pause_free_switch ? ST_ROLE_FAST : ST_PAUSE_ENC;
                    end
                    ST_PAUSE_ENC:
                    begin
                        move = 1'b1;
                        if (req.event_type == EVT_ENC_OFF && req.event_ok)
                            target = ST_ROLE;
                    end
                    ST_ROLE:
                    begin
                        // any event ends the role change
                        r.timer_cancel = 1'b1;
                        target = ST_RESTORE;
                        move = 1'b1;
                    end
                    ST_ROLE_FAST:
                    begin
                        r.timer_cancel = 1'b1;
                        move = 1'b1;
                    end
                    ST_RESTORE:
                    begin
                        r.timer_cancel = 1'b1;
                        if (!(req.event_type == EVT_ENC_ON && req.event_ok))
                            r.terminate_link = 1'b1;
                        move = 1'b1;
                    end
                    default:
                        move = 1'b0;
                endcase
            end
        endcase

        if (move)
        begin
            // leaving restore with encryption saved resumes traffic
            if (st.pos == ST_RESTORE && st.saved_enc)
                r.traffic_park = PARK_RESUME;
            chaining = 1'b1;
            while (chaining)
            begin
                st.pos = target;
                chaining = 1'b0;
                case (target)
                    ST_LEAVE_LP:
                    begin
                        r.cmd_leave_lowpower = 1'b1;
                        if (req.link_active)
                        begin
                            target = cfg.pause_free_switch ? ST_ROLE_FAST : ST_PAUSE_ENC;
                            chaining = 1'b1;
                        end
                        else
                            r.notify_request = NTF_ACTIVE;
                    end
                    ST_PAUSE_ENC:
                    begin
                        st.saved_enc = req.link_encrypted;
                        if (req.link_encrypted)
                        begin
                            r.traffic_park = PARK_SUSPEND;
                            r.notify_request = NTF_ENC_OFF;
                            r.cmd_encrypt = ENC_OFF;
                        end
                        else
                        begin
                            target = ST_ROLE;
                            chaining = 1'b1;
                        end
                    end
                    ST_ROLE, ST_ROLE_FAST:
                    begin
                        r.notify_request = NTF_ROLE;
                        r.cmd_change_role = 1'b1;
                    end
                    ST_RESTORE:
                    begin
                        if (st.saved_enc)
                        begin
                            r.timer_start = TMR_ONE_CMD;
                            r.notify_request = NTF_ENC_ON;
                            r.cmd_encrypt = ENC_ON;
                        end
                        else
                        begin
                            target = ST_IDLE;
                            chaining = 1'b1;
                        end
                    end
                    default:
                    begin
                        st.pos = ST_IDLE;
                        r.release_helper = 1'b1;
                    end
                endcase
            end
        end
        r.new_state = st.pos;
        return r;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report($sformatf("mismatch %s: expected %0h actual %0h", name, want, got));
    endtask

    function automatic lrs_item_t req(input lrs_kind_t kind, input lrs_evt_t etype,
                                      input logic ok, input logic active,
                                      input logic enc);
        lrs_item_t it;
        it.kind = kind;
        it.event_type = etype;
        it.event_ok = ok;
        it.link_active = active;
        it.link_encrypted = enc;
        return it;
    endfunction

    task automatic push_request(input lrs_item_t it);
        lrs_result_t unused;
        unused = role_switch_step(gen_state, cur_cfg, it);
        pending_requests.push_back(it);
        requests_queued++;
    endtask

    // request that moves the current switch forward, random link flags
    function automatic lrs_item_t next_wellformed(input lrs_state_t pos);
        lrs_item_t it;
        it = 7'($urandom);
        case (pos)
            ST_IDLE:
                it.kind = KIND_START;
            ST_LEAVE_LP:
            begin
                it.kind = KIND_EVENT;
                it.event_type = EVT_ACTIVE;
                it.event_ok = 1'b1;
            end
            ST_PAUSE_ENC:
            begin
                it.kind = KIND_EVENT;
                it.event_type = EVT_ENC_OFF;
                it.event_ok = 1'b1;
            end
            ST_ROLE, ST_ROLE_FAST:
                it.kind = ($urandom_range(3) == 0) ? KIND_TIMEOUT : KIND_EVENT;
            default:
            begin
                it.kind = ($urandom_range(9) == 0) ? KIND_TIMEOUT : KIND_EVENT;
                it.event_type = EVT_ENC_ON;
                it.event_ok = ($urandom_range(7) != 0);
            end
        endcase
        return it;
    endfunction

    // mostly well-formed switch sequences, one request in five pure noise;
    // events ignored in idle do not count
    task automatic gen_segment(input int count);
        int        made;
        lrs_item_t it;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 20)
                it = 7'($urandom);
            else
                it = next_wellformed(gen_state.pos);
            if (!(it.kind == KIND_EVENT && gen_state.pos == ST_IDLE))
                made++;
            push_request(it);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (requests_taken != requests_queued || predicted_actions.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write a register, then read it back
    task automatic apb_write(input logic idx, input logic val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'b0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", {31'b0, val}, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PAUSE_FREE)
            cur_cfg.pause_free_switch = val;
        else
            cur_cfg.wanted_role = val;
    endtask

    task automatic set_config(input logic role, input logic pause_free);
        apb_write(REG_WANTED_ROLE, role);
        apb_write(REG_PAUSE_FREE, pause_free);
    endtask

    task automatic run_segment(input int send_pct, input int recv_pct, input logic role,
                               input logic pause_free, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_config(role, pause_free);
        gen_segment(count);
        wait_drained();
    endtask

    // request driver: holds a request until taken, random gaps between requests
    always @(negedge clk)
    begin
        if (!item_ch.valid || item_taken)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_ch.valid <= 1'b1;
                item_ch.data <= pending_requests.pop_front();
            end
            else
                item_ch.valid <= 1'b0;
        end
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results first, then predict for a newly taken request
    always @(posedge clk)
    begin
        lrs_result_t want;
        lrs_result_t got;
        item_taken <= item_ch.valid && item_ch.ready;
        if (result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (predicted_actions.size() == 0)
                report("result with no request pending");
            else
            begin
                want = predicted_actions.pop_front();
                check_field("new_state", want.new_state, got.new_state);
                check_field("cmd_leave_lowpower", want.cmd_leave_lowpower,
                            got.cmd_leave_lowpower);
                check_field("cmd_change_role", want.cmd_change_role, got.cmd_change_role);
                check_field("cmd_encrypt", want.cmd_encrypt, got.cmd_encrypt);
                check_field("notify_request", want.notify_request, got.notify_request);
                check_field("notify_cancel", want.notify_cancel, got.notify_cancel);
                check_field("timer_cancel", want.timer_cancel, got.timer_cancel);
                check_field("timer_start", want.timer_start, got.timer_start);
                check_field("traffic_park", want.traffic_park, got.traffic_park);
                check_field("terminate_link", want.terminate_link, got.terminate_link);
                check_field("release_helper", want.release_helper, got.release_helper);
                check_field("fault", want.fault, got.fault);
            end
        end
        if (item_ch.valid && item_ch.ready)
        begin
            predicted_actions.push_back(role_switch_step(chk_state, cur_cfg, item_ch.data));
            requests_taken++;
        end
    end

    // watchdog: any handshake or register access counts as progress
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel
            || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        item_taken = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 51;
        requests_queued = 0;
        requests_taken = 0;
        mismatches = 0;
        gen_state = '{pos: ST_IDLE, saved_enc: 1'b0};
        chk_state = '{pos: ST_IDLE, saved_enc: 1'b0};
        cur_cfg = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed, encryption pause path
        set_config(1'b0, 1'b0);
        push_request(req(KIND_EVENT, EVT_OTHER, 1'b1, 1'b1, 1'b1));    // ignored in idle
        push_request(req(KIND_TIMEOUT, EVT_ACTIVE, 1'b0, 1'b0, 1'b0)); // idle re-entered
        push_request(req(KIND_ERROR, EVT_ENC_ON, 1'b1, 1'b1, 1'b1));   // error in idle
        push_request(req(KIND_START, EVT_ACTIVE, 1'b0, 1'b0, 1'b1));   // wait for active
        push_request(req(KIND_START, EVT_ACTIVE, 1'b1, 1'b1, 1'b1));   // start when busy
        push_request(req(KIND_EVENT, EVT_ACTIVE, 1'b0, 1'b1, 1'b1));   // failed, back idle
        push_request(req(KIND_START, EVT_OTHER, 1'b0, 1'b1, 1'b1));    // chain into pause
        push_request(req(KIND_EVENT, EVT_ENC_OFF, 1'b1, 1'b0, 1'b0));  // role change
        push_request(req(KIND_EVENT, EVT_OTHER, 1'b0, 1'b0, 1'b0));    // any event ends it
        push_request(req(KIND_EVENT, EVT_ENC_ON, 1'b1, 1'b0, 1'b0));   // restored, resume
        push_request(req(KIND_START, EVT_OTHER, 1'b1, 1'b1, 1'b0));    // chain to role
        push_request(req(KIND_TIMEOUT, EVT_OTHER, 1'b1, 1'b1, 1'b0));  // restore skipped
        push_request(req(KIND_START, EVT_ENC_OFF, 1'b0, 1'b1, 1'b1));
        push_request(req(KIND_TIMEOUT, EVT_OTHER, 1'b0, 1'b0, 1'b0));  // pause timeout
        push_request(req(KIND_EVENT, EVT_ENC_ON, 1'b0, 1'b1, 1'b1));   // restore failed
        push_request(req(KIND_START, EVT_ACTIVE, 1'b1, 1'b1, 1'b1));
        push_request(req(KIND_EVENT, EVT_ENC_OFF, 1'b0, 1'b1, 1'b1));  // pause failed
        push_request(req(KIND_START, EVT_ACTIVE, 1'b1, 1'b0, 1'b0));
        push_request(req(KIND_ERROR, EVT_OTHER, 1'b0, 1'b0, 1'b0));    // error mid switch
        push_request(req(KIND_START, EVT_ACTIVE, 1'b1, 1'b1, 1'b1));
        push_request(req(KIND_EVENT, EVT_ENC_OFF, 1'b1, 1'b1, 1'b1));
        push_request(req(KIND_TIMEOUT, EVT_OTHER, 1'b1, 1'b1, 1'b1));  // role timeout
        push_request(req(KIND_TIMEOUT, EVT_OTHER, 1'b1, 1'b1, 1'b1));  // restore timeout
        wait_drained();

        // directed, pause-free shortcut
        set_config(1'b1, 1'b1);
        push_request(req(KIND_START, EVT_OTHER, 1'b0, 1'b1, 1'b1));
        push_request(req(KIND_EVENT, EVT_OTHER, 1'b0, 1'b1, 1'b1));
        push_request(req(KIND_START, EVT_OTHER, 1'b0, 1'b0, 1'b1));
        push_request(req(KIND_EVENT, EVT_ACTIVE, 1'b1, 1'b0, 1'b1));
        push_request(req(KIND_TIMEOUT, EVT_OTHER, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // random: receiver then sender idling, then none, config varied per segment
        run_segment(18, 51, 1'b0, 1'b0, 125);
        run_segment(18, 51, 1'b1, 1'b1, 125);
        run_segment(51, 18, 1'b1, 1'b0, 125);
        run_segment(51, 18, 1'b0, 1'b1, 125);
        run_segment(0, 0, 1'b0, 1'b0, 125);
        run_segment(0, 0, 1'b1, 1'b1, 125);

        if (mismatches == 0 && predicted_actions.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
